### rtl/mura_mask_pixel_generator_assert.svh
// Assertion macros for the MURA mask pixel generator checkers.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef MURA_MASK_PIXEL_GENERATOR_ASSERT_SVH
`define MURA_MASK_PIXEL_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MMPG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MMPG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/mmpg_pkg.sv
// Shared constants for the MURA mask pixel generator.
// Used by the top level and by its port checker; depends on nothing else.
package mmpg_pkg;

   // Limits of the mask and of the bin pattern.
   localparam int MAX_ORDER = 64;
   localparam int MAX_BIN   = 8;

   // Field and register widths.
   localparam int ORDER_W     = 7;
   localparam int TRANS_W     = 8;
   localparam int TILE_W      = 7;
   localparam int SUB_W       = 3;
   localparam int WEIGHT_W    = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   // Weight store geometry: one entry per sub-pixel of the bin pattern.
   localparam int WDEPTH  = MAX_BIN * MAX_BIN;
   localparam int WADDR_W = $clog2(WDEPTH);

   // Signed tile offset, its magnitude, and the residue walk width.
   localparam int OFFSET_W = 9;
   localparam int MAG_W    = 8;
   localparam int RES_W    = $clog2(MAX_ORDER);

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_MASK_ORDER   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIN_SIZE     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSPARENCY = 2'd2;

   // Request opcodes.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Reset values and fixed numbers.
   localparam logic [ORDER_W-1:0]        MASK_ORDER_RESET   = 7'd2;
   localparam logic signed [TRANS_W-1:0] TRANSPARENCY_RESET = -8'sd1;
   localparam logic signed [TRANS_W-1:0] TRANS_PASS         = 8'sd1;
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_ONE        = 16'sd256;

endpackage

### rtl/mura_mask_pixel_generator.sv
// MURA coded-aperture mask pixel generator with a 64-entry bin weight store.
// Queries: the residue walk steps k = 1 .. p-1 through one shared residue unit
// (p is the order clamped to 64; order 0 or 1 skips the walk), then the result
// register is written. Loads leave the block idle, ready for the next request.
// A query holds req_stall until its result is written, and longer while the
// previous result waits on rsp_stall. Reset is synchronous: order 2,
// transparency -1, all bin weights read as 1.0.
module mura_mask_pixel_generator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_opcode,
   input  logic [mmpg_pkg::TILE_W-1:0]           req_tile_row,
   input  logic [mmpg_pkg::TILE_W-1:0]           req_tile_col,
   input  logic [mmpg_pkg::SUB_W-1:0]            req_sub_row,
   input  logic [mmpg_pkg::SUB_W-1:0]            req_sub_col,
   input  logic signed [mmpg_pkg::WEIGHT_W-1:0]  req_weight_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [mmpg_pkg::WEIGHT_W-1:0]  rsp_pixel_value,
   output logic                                  rsp_tile_open,
   input  logic                                  csr_write_enable,
   input  logic [mmpg_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mmpg_pkg::CSR_DATA_W-1:0]       csr_write_data
);
   import mmpg_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_type;

   // Control and datapath registers with their next values.
   state_type                  state_ff, state_in;
   logic [ORDER_W-1:0]         mask_order_ff, mask_order_in;
   logic signed [TRANS_W-1:0]  trans_ff, trans_in;
   logic [WDEPTH-1:0]          wvalid_ff, wvalid_in;
   logic                       sel_valid_ff, sel_valid_in;
   logic [ORDER_W-1:0]         p_ff, p_in;
   logic [RES_W-1:0]           res_ff, res_in;
   logic [RES_W-1:0]           step_ff, step_in;
   logic [RES_W-1:0]           cnt_ff, cnt_in;
   logic [MAG_W-1:0]           mag_a_ff, mag_a_in;
   logic [MAG_W-1:0]           mag_b_ff, mag_b_in;
   logic                       hit_a_ff, hit_a_in;
   logic                       hit_b_ff, hit_b_in;
   logic                       a_zero_ff, a_zero_in;
   logic                       b_zero_ff, b_zero_in;
   logic                       diag_ff, diag_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [WEIGHT_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic                       rsp_open_ff, rsp_open_in;

   // Weight store and its registered read port.
   logic signed [WEIGHT_W-1:0] weight_mem [WDEPTH];
   logic signed [WEIGHT_W-1:0] rd_weight_ff;

   // Decode helpers.
   logic                       req_transfer;
   logic                       mem_write;
   logic                       mem_read;
   logic [WADDR_W-1:0]         req_addr;
   logic [ORDER_W-1:0]         p_eff;
   logic signed [OFFSET_W-1:0] off_row;
   logic signed [OFFSET_W-1:0] off_col;
   logic [ORDER_W-1:0]         res_sum;
   logic [ORDER_W-1:0]         step_sum;
   logic                       open_now;
   logic signed [WEIGHT_W-1:0] weight_sel;

   // Signed offset of a tile index from the centre of the mask.
   function automatic logic signed [OFFSET_W-1:0] tile_offset(
      input logic [TILE_W-1:0]  t,
      input logic [ORDER_W-1:0] p
   );
      logic signed [OFFSET_W-1:0] ts;
      logic signed [OFFSET_W-1:0] ps;
      ts = signed'(OFFSET_W'(t));
      ps = signed'(OFFSET_W'(p));
      if (t < p) begin
         return ts - ps + 9'sd1;
      end
      return ts - (ps <<< 1) + 9'sd1;
   endfunction

   // Magnitude of an offset; it never exceeds 128.
   function automatic logic [MAG_W-1:0] offset_mag(input logic signed [OFFSET_W-1:0] off);
      logic signed [OFFSET_W-1:0] neg;
      neg = -off;
      return off[OFFSET_W-1] ? MAG_W'(neg) : MAG_W'(off);
   endfunction

   assign req_stall    = (state_ff != ST_IDLE);
   assign req_transfer = req_valid && !req_stall;
   assign req_addr     = {req_sub_row, req_sub_col};
   assign mem_write    = req_transfer && (req_opcode == OP_LOAD);
   assign mem_read     = req_transfer && (req_opcode == OP_QUERY);

   assign p_eff   = (mask_order_ff > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : mask_order_ff;
   assign off_row = tile_offset(req_tile_row, p_eff);
   assign off_col = tile_offset(req_tile_col, p_eff);

   // Shared residue unit: k*k mod p and 2k+1 mod p advance by one add and compare each.
   assign res_sum  = {1'b0, res_ff} + {1'b0, step_ff};
   assign step_sum = {1'b0, step_ff} + 7'd2;

   // Final decision on the tile and the pixel value.
   assign open_now   = diag_ff || (!a_zero_ff && (b_zero_ff || (hit_a_ff == hit_b_ff)));
   assign weight_sel = sel_valid_ff ? rd_weight_ff : WEIGHT_ONE;

   // Next-state logic for the sequencer, the registers and the result stage.
   always_comb begin
      state_in      = state_ff;
      mask_order_in = mask_order_ff;
      trans_in      = trans_ff;
      wvalid_in     = wvalid_ff;
      sel_valid_in  = sel_valid_ff;
      p_in          = p_ff;
      res_in        = res_ff;
      step_in       = step_ff;
      cnt_in        = cnt_ff;
      mag_a_in      = mag_a_ff;
      mag_b_in      = mag_b_ff;
      hit_a_in      = hit_a_ff;
      hit_b_in      = hit_b_ff;
      a_zero_in     = a_zero_ff;
      b_zero_in     = b_zero_ff;
      diag_in       = diag_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_open_in   = rsp_open_ff;

      // Register writes; the bin size is informational and is not stored.
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MASK_ORDER:   mask_order_in = csr_write_data[ORDER_W-1:0];
            CSR_BIN_SIZE:     ;
            CSR_TRANSPARENCY: trans_in = signed'(csr_write_data[TRANS_W-1:0]);
            default:          ;
         endcase
      end

      // A delivered result frees the output register.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_transfer) begin
               if (req_opcode == OP_LOAD) begin
                  wvalid_in[req_addr] = 1'b1;
               end else begin
                  sel_valid_in = wvalid_ff[req_addr];
                  p_in         = p_eff;
                  mag_a_in     = offset_mag(off_row);
                  mag_b_in     = offset_mag(off_col);
                  a_zero_in    = (off_row == '0);
                  b_zero_in    = (off_col == '0);
                  diag_in      = (req_tile_row == req_tile_col);
                  hit_a_in     = 1'b0;
                  hit_b_in     = 1'b0;
                  // Walk starts at k = 1: residue 1, step 3 mod p.
                  res_in       = RES_W'(1);
                  if (p_eff == 7'd2) begin
                     step_in = RES_W'(1);
                  end else if (p_eff == 7'd3) begin
                     step_in = '0;
                  end else begin
                     step_in = RES_W'(3);
                  end
                  cnt_in       = RES_W'(p_eff - 7'd1);
                  if (p_eff >= 7'd2) begin
                     state_in = ST_SCAN;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (({2'b00, res_ff} == mag_a_ff) && (mag_a_ff != '0)) begin
               hit_a_in = 1'b1;
            end
            if (({2'b00, res_ff} == mag_b_ff) && (mag_b_ff != '0)) begin
               hit_b_in = 1'b1;
            end
            res_in  = (res_sum >= p_ff) ? RES_W'(res_sum - p_ff) : RES_W'(res_sum);
            step_in = (step_sum >= p_ff) ? RES_W'(step_sum - p_ff) : RES_W'(step_sum);
            cnt_in  = cnt_ff - RES_W'(1);
            if (cnt_ff == RES_W'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_open_in  = open_now;
               if (open_now || (trans_ff == TRANS_PASS)) begin
                  rsp_pixel_in = weight_sel;
               end else begin
                  rsp_pixel_in = signed'({trans_ff, 8'h00});
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, configuration, walk and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mask_order_ff <= MASK_ORDER_RESET;
         trans_ff      <= TRANSPARENCY_RESET;
         wvalid_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mask_order_ff <= mask_order_in;
         trans_ff      <= trans_in;
         wvalid_ff     <= wvalid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      sel_valid_ff <= sel_valid_in;
      p_ff         <= p_in;
      res_ff       <= res_in;
      step_ff      <= step_in;
      cnt_ff       <= cnt_in;
      mag_a_ff     <= mag_a_in;
      mag_b_ff     <= mag_b_in;
      hit_a_ff     <= hit_a_in;
      hit_b_ff     <= hit_b_in;
      a_zero_ff    <= a_zero_in;
      b_zero_ff    <= b_zero_in;
      diag_ff      <= diag_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_open_ff  <= rsp_open_in;
   end

   // Bin weight store: one write port for loads, one registered read for queries.
   always_ff @(posedge clock) begin
      if (mem_write) begin
         weight_mem[req_addr] <= req_weight_value;
      end
      if (mem_read) begin
         rd_weight_ff <= weight_mem[req_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_pixel_ff;
   assign rsp_tile_open   = rsp_open_ff;

endmodule

### rtl/mmpg_checker.sv
// Port-level checker for the MURA mask pixel generator, attached by bind.
// Depends on mmpg_pkg and on the assertion macros header.
`include "mura_mask_pixel_generator_assert.svh"

module mmpg_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  req_opcode,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [mmpg_pkg::WEIGHT_W-1:0]  rsp_pixel_value,
   input logic                                  rsp_tile_open
);
   import mmpg_pkg::*;

   // A stalled result keeps its payload.
   `MMPG_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pixel_value) && $stable(rsp_tile_open), "result changed while stalled")

   // A query transfer occupies the block for at least the following cycle.
   `MMPG_ASSERT_NEXT(a_query_busy, req_valid && !req_stall && req_opcode == OP_QUERY, req_stall, "block free right after a query")

   // A load transfer leaves the block free in the following cycle.
   `MMPG_ASSERT_NEXT(a_load_free, req_valid && !req_stall && req_opcode == OP_LOAD, !req_stall, "block busy after a load")

   // A new result only appears at the end of a query.
   `MMPG_ASSERT_NOW(a_rsp_from_query, $rose(rsp_valid), $past(req_stall), "result without a query in progress")

endmodule

bind mura_mask_pixel_generator mmpg_checker u_mmpg_checker (.*);

### bench/tb.sv
// Self-checking bench for the MURA mask pixel generator: directed and random traffic.
// Depends on mmpg_pkg and on the top level mura_mask_pixel_generator; includes no files.
`timescale 1ns / 1ps

module tb;
   import mmpg_pkg::*;

   localparam int SETTLE_CYCLES  = MAX_ORDER + 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_ITEMS    = 150;

   typedef struct packed {
      logic signed [WEIGHT_W-1:0] pixel_value;
      logic                       tile_open;
   } pixel_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_opcode = OP_LOAD;
   logic [TILE_W-1:0]           req_tile_row = '0;
   logic [TILE_W-1:0]           req_tile_col = '0;
   logic [SUB_W-1:0]            req_sub_row = '0;
   logic [SUB_W-1:0]            req_sub_col = '0;
   logic signed [WEIGHT_W-1:0]  req_weight_value = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [WEIGHT_W-1:0]  rsp_pixel_value;
   logic                        rsp_tile_open;
   logic                        csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]      csr_index = CSR_MASK_ORDER;
   logic [CSR_DATA_W-1:0]       csr_write_data = '0;

   // Local copy of the block's registers and bin weight store.
   logic [ORDER_W-1:0]          order_reg;
   logic signed [TRANS_W-1:0]   trans_reg;
   logic signed [WEIGHT_W-1:0]  weight_store [WDEPTH];

   pixel_result_type            pending_pixels [$];
   int                          mismatch_count = 0;
   int                          loads_sent = 0;
   int                          queries_sent = 0;
   int                          open_seen = 0;
   int                          closed_seen = 0;
   int                          settings_used = 0;
   int                          rsp_hold_left = 0;
   int                          quiet_cycles = 0;
   bit                          gaps_on = 1'b1;

   mura_mask_pixel_generator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_tile_row     (req_tile_row),
      .req_tile_col     (req_tile_col),
      .req_sub_row      (req_sub_row),
      .req_sub_col      (req_sub_col),
      .req_weight_value (req_weight_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_tile_open    (rsp_tile_open),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Number of idle cycles before the next transfer on either side.
   function automatic int draw_wait();
      return gaps_on ? $urandom_range(0, 19) : 0;
   endfunction

   function automatic int effective_order();
      return (order_reg > MAX_ORDER) ? MAX_ORDER : int'(order_reg);
   endfunction

   // Signed offset of a tile index from the centre of the mask.
   function automatic int tile_offset(int t, int p);
      if (t <= p - 1) return t - (p - 1);
      return t - 2 * p + 1;
   endfunction

   function automatic bit is_quadratic_residue(int x, int p);
      if (x == 0 || p < 1) return 1'b0;
      for (int k = 1; k < p; k++) begin
         if ((k * k) % p == x) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Decodes the tile and selects either the bin weight or the transparency.
   function automatic pixel_result_type predict_pixel(logic [TILE_W-1:0] row,
                                                      logic [TILE_W-1:0] col,
                                                      logic [SUB_W-1:0] sr,
                                                      logic [SUB_W-1:0] sc);
      pixel_result_type res;
      int p;
      int a;
      int b;
      p = effective_order();
      a = tile_offset(int'(row), p);
      b = tile_offset(int'(col), p);
      if (row == col) begin
         res.tile_open = 1'b1;
      end else if (a == 0) begin
         res.tile_open = 1'b0;
      end else if (b == 0) begin
         res.tile_open = 1'b1;
      end else begin
         res.tile_open = is_quadratic_residue((a < 0) ? -a : a, p)
                         == is_quadratic_residue((b < 0) ? -b : b, p);
      end
      if (res.tile_open || trans_reg == TRANS_PASS) begin
         res.pixel_value = weight_store[{sr, sc}];
      end else begin
         res.pixel_value = {trans_reg, 8'h00};
      end
      return res;
   endfunction

   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   // Sends one request and updates the local state once the transfer happens.
   task automatic transfer_request(logic op, logic [TILE_W-1:0] row,
                                   logic [TILE_W-1:0] col, logic [SUB_W-1:0] sr,
                                   logic [SUB_W-1:0] sc,
                                   logic signed [WEIGHT_W-1:0] weight);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_opcode       <= op;
      req_tile_row     <= row;
      req_tile_col     <= col;
      req_sub_row      <= sr;
      req_sub_col      <= sc;
      req_weight_value <= weight;
      req_valid        <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (op == OP_LOAD) begin
         weight_store[{sr, sc}] = weight;
         loads_sent++;
      end else begin
         pending_pixels.push_back(predict_pixel(row, col, sr, sc));
         queries_sent++;
      end
   endtask

   // Holds the sender back until every expected pixel has come out.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
   endtask

   // A load leaves no result behind, so allow the longest query time as well.
   task automatic settle_block();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers on consecutive cycles while the block is idle.
   task automatic program_registers(logic [CSR_DATA_W-1:0] order,
                                    logic [CSR_DATA_W-1:0] bin,
                                    logic [CSR_DATA_W-1:0] trans);
      settle_block();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_MASK_ORDER;
      csr_write_data   <= order;
      @(posedge clock);
      csr_index        <= CSR_BIN_SIZE;
      csr_write_data   <= bin;
      @(posedge clock);
      csr_index        <= CSR_TRANSPARENCY;
      csr_write_data   <= trans;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      order_reg    = order[ORDER_W-1:0];
      trans_reg    = trans;
      settings_used++;
   endtask

   // Tile index, mostly inside the mask, sometimes on the zero offset or anywhere.
   function automatic logic [TILE_W-1:0] pick_tile(int p);
      int top;
      int pick;
      top  = (p >= 2) ? 2 * p - 2 : 3;
      pick = $urandom_range(0, 19);
      if (pick == 0) return TILE_W'(p - 1);
      if (pick <= 2) return TILE_W'($urandom_range(0, 127));
      return TILE_W'($urandom_range(0, top));
   endfunction

   task automatic send_random_item();
      logic [31:0] r;
      logic [TILE_W-1:0] row;
      logic [TILE_W-1:0] col;
      int p;
      r   = $urandom();
      p   = effective_order();
      row = pick_tile(p);
      col = ($urandom_range(0, 6) == 0) ? row : pick_tile(p);
      if ($urandom_range(0, 9) < 3) begin
         transfer_request(OP_LOAD, r[22:16], r[29:23], r[18:16], r[21:19], r[15:0]);
      end else begin
         transfer_request(OP_QUERY, row, col, r[18:16], r[21:19], r[15:0]);
      end
   endtask

   // After reset: order 2, transparency -1 and every weight at 1.0.
   task automatic test_reset_state();
      transfer_request(OP_QUERY, 7'd0, 7'd0, 3'd0, 3'd0, 16'sd0);
      transfer_request(OP_QUERY, 7'd0, 7'd1, 3'd7, 3'd7, 16'sd0);
      transfer_request(OP_QUERY, 7'd1, 7'd0, 3'd3, 3'd5, 16'sd0);
      transfer_request(OP_QUERY, 7'd2, 7'd0, 3'd0, 3'd7, 16'sd0);
   endtask

   // Weight extremes, every decoding branch and the odd register values.
   task automatic test_mask_decoding();
      program_registers(8'd5, 8'd8, 8'd127);
      transfer_request(OP_LOAD, 7'd0, 7'd0, 3'd7, 3'd7, 16'sh7FFF);
      transfer_request(OP_LOAD, 7'd127, 7'd127, 3'd0, 3'd0, -16'sh8000);
      // Residue signs agree, then differ.
      transfer_request(OP_QUERY, 7'd0, 7'd8, 3'd7, 3'd7, 16'sd0);
      transfer_request(OP_QUERY, 7'd0, 7'd2, 3'd7, 3'd7, 16'sd0);
      // Zero row offset is closed, zero column offset is open.
      transfer_request(OP_QUERY, 7'd4, 7'd0, 3'd0, 3'd0, 16'sd0);
      transfer_request(OP_QUERY, 7'd1, 7'd4, 3'd0, 3'd0, 16'sd0);
      // Tile index well beyond the mask.
      transfer_request(OP_QUERY, 7'd126, 7'd0, 3'd3, 3'd3, 16'sd0);

      // Order above the limit saturates; bit 7 of the write is dropped.
      program_registers(8'hFF, 8'd0, 8'h80);
      transfer_request(OP_QUERY, 7'd126, 7'd126, 3'd7, 3'd7, 16'sd0);
      transfer_request(OP_QUERY, 7'd10, 7'd63, 3'd0, 3'd0, 16'sd0);
      transfer_request(OP_LOAD, 7'd0, 7'd0, 3'd3, 3'd3, 16'sd0);
      transfer_request(OP_QUERY, 7'd126, 7'd126, 3'd3, 3'd3, 16'sd0);

      // Degenerate orders with no residues; transparency of one passes weights.
      program_registers(8'd0, 8'd15, 8'd1);
      transfer_request(OP_QUERY, 7'd5, 7'd3, 3'd7, 3'd7, 16'sd0);
      transfer_request(OP_QUERY, 7'd0, 7'd1, 3'd0, 3'd0, 16'sd0);
      program_registers(8'd1, 8'd1, 8'hFF);
      transfer_request(OP_QUERY, 7'd0, 7'd1, 3'd0, 3'd0, 16'sd0);
      transfer_request(OP_QUERY, 7'd1, 7'd0, 3'd7, 3'd7, 16'sd0);
   endtask

   // Random traffic over several register settings, with and without idling.
   task automatic test_random_traffic();
      int orders [RANDOM_PHASES] = '{3, 64, 127, 5, 0, 7, 1, 2, 13, -1, 61, -1};
      logic [CSR_DATA_W-1:0] order;
      logic [CSR_DATA_W-1:0] trans;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         order = (orders[ph] < 0) ? CSR_DATA_W'($urandom_range(0, 255))
                                  : CSR_DATA_W'(orders[ph]);
         if ($urandom_range(0, 1) == 1) order[7] = 1'b1;
         unique case (ph % 4)
            0: trans = 8'd1;
            1: trans = 8'h80;
            2: trans = 8'h7F;
            default: trans = CSR_DATA_W'($urandom_range(0, 255));
         endcase
         gaps_on = 1'b1;
         program_registers(order, CSR_DATA_W'($urandom_range(0, 255)), trans);
         gaps_on = (ph % 2 == 0);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Halfway through, let the block empty completely before going on.
            if (i == PHASE_ITEMS / 2) drain_results();
            send_random_item();
         end
      end
      gaps_on = 1'b1;
   endtask

   // Result side: stall for a drawn number of cycles per result.
   always @(posedge clock) begin : drive_result_stall
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         rsp_hold_left = draw_wait();
      end else if (rsp_valid === 1'b1 && rsp_hold_left > 0) begin
         rsp_hold_left--;
      end
      rsp_stall <= (rsp_hold_left > 0);
   end

   // Compare every result transfer with the oldest expected pixel.
   always @(posedge clock) begin : check_results
      pixel_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("result transfer with no query outstanding");
         end else begin
            want = pending_pixels.pop_front();
            if (want.tile_open) open_seen++;
            else closed_seen++;
            if (rsp_pixel_value !== want.pixel_value)
               report_mismatch($sformatf("pixel_value got %0d expected %0d",
                                         rsp_pixel_value, want.pixel_value));
            if (rsp_tile_open !== want.tile_open)
               report_mismatch($sformatf("tile_open got %b expected %b",
                                         rsp_tile_open, want.tile_open));
         end
      end
   end

   // Ends the run when neither channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid === 1'b1 && req_stall === 1'b0)
          || (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d cycles without a transfer", quiet_cycles);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      order_reg    = MASK_ORDER_RESET;
      trans_reg    = TRANSPARENCY_RESET;
      for (int i = 0; i < WDEPTH; i++) weight_store[i] = WEIGHT_ONE;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_mask_decoding();
      test_random_traffic();
      settle_block();

      $display("Sent %0d weight loads and %0d pixel queries over %0d register settings;",
               loads_sent, queries_sent, settings_used);
      $display("checked %0d open and %0d closed tiles.", open_seen, closed_seen);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### mura_mask_pixel_generator.f
+incdir+rtl
rtl/mmpg_pkg.sv
rtl/mura_mask_pixel_generator.sv
rtl/mmpg_checker.sv
bench/tb.sv
